// ----- src/lagrange_interpolation_eval_defines.svh -----
// ----------------------------------------------------------------------------
// lagrange_interpolation_eval_defines
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef LAGRANGE_INTERPOLATION_EVAL_DEFINES_SVH
`define LAGRANGE_INTERPOLATION_EVAL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LIE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LIE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/lie_pkg.sv -----
// ----------------------------------------------------------------------------
// lie_pkg
// shared types, constants and fixed-point helpers of the interpolator
// ----------------------------------------------------------------------------
package lie_pkg;

	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int PCOUNT_W   = 5;
	localparam int FQ_DEPTH   = 2;
	localparam int DIV_STEPS  = 65;
	localparam int MUL_STEPS  = 5;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_DUP  = 2'd2;
	localparam logic [1:0] STAT_SAT  = 2'd3;

	localparam logic [63:0] SIGN64   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAXPOS64 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_EVAL   = 2'd2,
		OP_NOP    = 2'd3
	} op_e;

	typedef struct packed {
		op_e                op;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} cmd_t;

	typedef struct packed {
		logic               start;
		logic signed [32:0] num;
		logic signed [32:0] den;
	} div_req_t;

	typedef struct packed {
		logic        start;
		logic        frac16;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] value;
		logic        sat;
	} arith_rsp_t;

	typedef struct packed {
		logic [63:0] value;
		logic        sat;
	} satval_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_DCHK,
		B_DRD,
		B_DCMP,
		B_IRD,
		B_ILAT,
		B_JCHK,
		B_JRD,
		B_JDIV,
		B_JDIVW,
		B_JMULW,
		B_TMUL,
		B_TMULW,
		B_DONE
	} bst_e;

	function automatic satval_t clamp_q(input logic neg, input logic [63:0] mag,
			input logic over);
		satval_t r;
		r.sat   = 1'b0;
		r.value = mag;
		if (neg) begin
			if (over || (mag > SIGN64)) begin
				r.sat   = 1'b1;
				r.value = SIGN64;
			end else begin
				r.value = 64'd0 - mag;
			end
		end else if (over || (mag > MAXPOS64)) begin
			r.sat   = 1'b1;
			r.value = MAXPOS64;
		end
		return r;
	endfunction

	function automatic satval_t sat_add(input logic [63:0] a, input logic [63:0] b);
		satval_t     r;
		logic [63:0] s;
		s       = a + b;
		r.sat   = 1'b0;
		r.value = s;
		if ((a[63] == b[63]) && (s[63] != a[63])) begin
			r.sat   = 1'b1;
			r.value = a[63] ? SIGN64 : MAXPOS64;
		end
		return r;
	endfunction

endpackage

// ----- src/lie_ifs.sv -----
// ----------------------------------------------------------------------------
// lie_ifs
// item channels of the interpolator: command in, result out
// ----------------------------------------------------------------------------
interface lie_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;

	modport source (output valid, output opcode, output coord_x, output coord_y,
		input ready);
	modport sink (input valid, input opcode, input coord_x, input coord_y,
		output ready);
endinterface

interface lie_out_if;
	logic                        valid;
	logic                        ready;
	logic signed [63:0]          interp_value;
	logic [1:0]                  status;
	logic [lie_pkg::PCOUNT_W-1:0] point_count;

	modport source (output valid, output interp_value, output status,
		output point_count, input ready);
	modport sink (input valid, input interp_value, input status,
		input point_count, output ready);
endinterface

// ----- src/lie_front.sv -----
// ----------------------------------------------------------------------------
// lie_front
// accepts items, decodes the opcode and queues commands for the back end
// ----------------------------------------------------------------------------
module lie_front (
	input  logic          clk,
	input  logic          arst_n,
	lie_in_if.sink        in_ch,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output lie_pkg::cmd_t cmd
);

	localparam int PTR_W = $clog2(lie_pkg::FQ_DEPTH);
	localparam int QC_W  = $clog2(lie_pkg::FQ_DEPTH + 1);

	lie_pkg::cmd_t          fq_q [lie_pkg::FQ_DEPTH];
	logic [PTR_W-1:0]       wp_q;
	logic [PTR_W-1:0]       rp_q;
	logic [QC_W-1:0]        cnt_q;
	lie_pkg::cmd_t          dec;
	logic                   push;
	logic                   pop;

	// classify
	always_comb begin
		dec.x = in_ch.coord_x;
		dec.y = in_ch.coord_y;
		case (in_ch.opcode)
			lie_pkg::OP_CLEAR:  dec.op = lie_pkg::OP_CLEAR;
			lie_pkg::OP_APPEND: dec.op = lie_pkg::OP_APPEND;
			lie_pkg::OP_EVAL:   dec.op = lie_pkg::OP_EVAL;
			default:            dec.op = lie_pkg::OP_NOP;
		endcase
	end

	assign in_ch.ready = (cnt_q != QC_W'(lie_pkg::FQ_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign cmd_valid   = (cnt_q != '0);
	assign pop         = cmd_valid && cmd_ready;
	assign cmd         = fq_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fq_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/lie_div.sv -----
// ----------------------------------------------------------------------------
// lie_div
// restoring divider, one quotient bit a cycle, Q32.32 result with clamping
// ----------------------------------------------------------------------------
module lie_div (
	input  logic                clk,
	input  logic                arst_n,
	input  lie_pkg::div_req_t   req,
	output lie_pkg::arith_rsp_t rsp
);

	localparam int SC_W = $clog2(lie_pkg::DIV_STEPS + 1);

	logic              busy_q;
	logic [SC_W-1:0]   cnt_q;
	logic [33:0]       rem_q;
	logic [64:0]       dq_q;
	logic [32:0]       md_q;
	logic              neg_q;
	logic [32:0]       mn;
	logic [32:0]       md;
	logic [33:0]       rem_sh;
	logic              ge;
	lie_pkg::satval_t  cl;

	assign mn     = req.num[32] ? (33'd0 - req.num) : req.num;
	assign md     = req.den[32] ? (33'd0 - req.den) : req.den;
	assign rem_sh = {rem_q[32:0], dq_q[64]};
	assign ge     = (rem_sh >= {1'b0, md_q});

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q  <= {mn, 32'd0};
			md_q  <= md;
			neg_q <= req.num[32] ^ req.den[32];
		end else if (busy_q && (cnt_q != SC_W'(lie_pkg::DIV_STEPS))) begin
			rem_q <= ge ? (rem_sh - {1'b0, md_q}) : rem_sh;
			dq_q  <= {dq_q[63:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == SC_W'(lie_pkg::DIV_STEPS)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign cl        = lie_pkg::clamp_q(neg_q, dq_q[63:0], dq_q[64]);
	assign rsp.done  = busy_q && (cnt_q == SC_W'(lie_pkg::DIV_STEPS));
	assign rsp.value = cl.value;
	assign rsp.sat   = cl.sat;

endmodule

// ----- src/lie_mul.sv -----
// ----------------------------------------------------------------------------
// lie_mul
// 64 by 64 magnitude multiply from four 32 by 32 partial products, shift, clamp
// ----------------------------------------------------------------------------
module lie_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  lie_pkg::mul_req_t   req,
	output lie_pkg::arith_rsp_t rsp
);

	localparam int MC_W = $clog2(lie_pkg::MUL_STEPS + 1);

	logic              busy_q;
	logic [MC_W-1:0]   cnt_q;
	logic [63:0]       ma_q;
	logic [63:0]       mb_q;
	logic              neg_q;
	logic              f16_q;
	logic [63:0]       p_q;
	logic [1:0]        pidx_q;
	logic              pv_q;
	logic [127:0]      acc_q;
	logic [31:0]       ah;
	logic [31:0]       bh;
	logic [127:0]      addend;
	logic [63:0]       m;
	logic              over;
	lie_pkg::satval_t  cl;

	assign ah = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign bh = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];

	always_comb begin
		case (pidx_q)
			2'b00:   addend = {64'd0, p_q};
			2'b11:   addend = {p_q, 64'd0};
			default: addend = {32'd0, p_q, 32'd0};
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q  <= req.a[63] ? (64'd0 - req.a) : req.a;
			mb_q  <= req.b[63] ? (64'd0 - req.b) : req.b;
			neg_q <= req.a[63] ^ req.b[63];
			f16_q <= req.frac16;
			acc_q <= '0;
		end else if (busy_q) begin
			p_q    <= ah * bh;
			pidx_q <= cnt_q[1:0];
			if (pv_q) begin
				acc_q <= acc_q + addend;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			pv_q   <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			pv_q   <= 1'b0;
		end else if (busy_q) begin
			pv_q <= (cnt_q < MC_W'(4));
			if (cnt_q == MC_W'(lie_pkg::MUL_STEPS)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		if (f16_q) begin
			m    = acc_q[79:16];
			over = |acc_q[127:80];
		end else begin
			m    = acc_q[95:32];
			over = |acc_q[127:96];
		end
	end

	assign cl        = lie_pkg::clamp_q(neg_q, m, over);
	assign rsp.done  = busy_q && (cnt_q == MC_W'(lie_pkg::MUL_STEPS));
	assign rsp.value = cl.value;
	assign rsp.sat   = cl.sat;

endmodule

// ----- src/lie_back.sv -----
// ----------------------------------------------------------------------------
// lie_back
// point table, evaluation sequencer and result register
// ----------------------------------------------------------------------------
module lie_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  lie_pkg::cmd_t cmd,
	lie_out_if.source     out_ch
);

	localparam int IW = lie_pkg::IDX_W;
	localparam int CW = lie_pkg::CNT_W;

	logic [31:0]          xmem [lie_pkg::MAX_POINTS];
	logic [31:0]          ymem [lie_pkg::MAX_POINTS];
	logic [31:0]          rda_q;
	logic [31:0]          rdb_q;
	logic [31:0]          rdy_q;

	lie_pkg::bst_e        st_q;
	lie_pkg::bst_e        st_d;
	logic [CW-1:0]        held_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        i_q;
	logic [CW-1:0]        j_q;
	logic [31:0]          xq_q;
	logic [31:0]          xi_q;
	logic [31:0]          yi_q;
	logic [63:0]          w_q;
	logic [63:0]          sum_q;
	logic                 sat_q;

	logic                 ov_q;
	logic [63:0]          val_q;
	logic [1:0]           stat_q;
	logic [lie_pkg::PCOUNT_W-1:0] pc_q;

	logic                 out_free;
	logic                 take;
	logic                 full;
	logic                 res_load;
	lie_pkg::div_req_t    dreq;
	lie_pkg::mul_req_t    mreq;
	lie_pkg::arith_rsp_t  drsp;
	lie_pkg::arith_rsp_t  mrsp;
	lie_pkg::satval_t     acc;

	lie_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	lie_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	assign out_free  = !ov_q || out_ch.ready;
	assign cmd_ready = (st_q == lie_pkg::B_IDLE) && out_free;
	assign take      = cmd_valid && cmd_ready;
	assign full      = (held_q >= CW'(lie_pkg::MAX_POINTS));
	assign acc       = lie_pkg::sat_add(sum_q, mrsp.value);
	assign res_load  = (take && (cmd.op != lie_pkg::OP_EVAL))
		|| ((st_q == lie_pkg::B_DONE) && out_free);

	// table
	always_ff @(posedge clk) begin
		if (take && (cmd.op == lie_pkg::OP_APPEND) && !full) begin
			xmem[held_q[IW-1:0]] <= cmd.x;
			ymem[held_q[IW-1:0]] <= cmd.y;
		end
		rda_q <= xmem[i_q[IW-1:0]];
		rdb_q <= xmem[j_q[IW-1:0]];
		rdy_q <= ymem[i_q[IW-1:0]];
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			lie_pkg::B_IDLE: begin
				if (take && (cmd.op == lie_pkg::OP_EVAL)) begin
					st_d = lie_pkg::B_DCHK;
				end
			end
			lie_pkg::B_DCHK: begin
				if (j_q < n_q) begin
					st_d = lie_pkg::B_DRD;
				end else if ((i_q + CW'(2)) >= n_q) begin
					st_d = lie_pkg::B_IRD;
				end
			end
			lie_pkg::B_DRD:  st_d = lie_pkg::B_DCMP;
			lie_pkg::B_DCMP: st_d = (rda_q == rdb_q) ? lie_pkg::B_DONE : lie_pkg::B_DCHK;
			lie_pkg::B_IRD:  st_d = (i_q >= n_q) ? lie_pkg::B_DONE : lie_pkg::B_ILAT;
			lie_pkg::B_ILAT: st_d = lie_pkg::B_JCHK;
			lie_pkg::B_JCHK: begin
				if (j_q >= n_q) begin
					st_d = lie_pkg::B_TMUL;
				end else if (j_q != i_q) begin
					st_d = lie_pkg::B_JRD;
				end
			end
			lie_pkg::B_JRD:   st_d = lie_pkg::B_JDIV;
			lie_pkg::B_JDIV:  st_d = lie_pkg::B_JDIVW;
			lie_pkg::B_JDIVW: st_d = drsp.done ? lie_pkg::B_JMULW : lie_pkg::B_JDIVW;
			lie_pkg::B_JMULW: st_d = mrsp.done ? lie_pkg::B_JCHK : lie_pkg::B_JMULW;
			lie_pkg::B_TMUL:  st_d = lie_pkg::B_TMULW;
			lie_pkg::B_TMULW: st_d = mrsp.done ? lie_pkg::B_IRD : lie_pkg::B_TMULW;
			lie_pkg::B_DONE:  st_d = out_free ? lie_pkg::B_IDLE : lie_pkg::B_DONE;
			default:          st_d = lie_pkg::B_IDLE;
		endcase
	end

	// unit requests
	always_comb begin
		dreq.start = (st_q == lie_pkg::B_JDIV);
		dreq.num   = {xq_q[31], xq_q} - {rdb_q[31], rdb_q};
		dreq.den   = {xi_q[31], xi_q} - {rdb_q[31], rdb_q};
		mreq.start = ((st_q == lie_pkg::B_JDIVW) && drsp.done)
			|| (st_q == lie_pkg::B_TMUL);
		mreq.frac16 = (st_q == lie_pkg::B_TMUL);
		if (st_q == lie_pkg::B_TMUL) begin
			mreq.a = {{32{yi_q[31]}}, yi_q};
			mreq.b = w_q;
		end else begin
			mreq.a = w_q;
			mreq.b = drsp.value;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			lie_pkg::B_IDLE: begin
				xq_q  <= cmd.x;
				sum_q <= '0;
			end
			lie_pkg::B_ILAT: begin
				xi_q <= rda_q;
				yi_q <= rdy_q;
				w_q  <= lie_pkg::ONE_Q32;
			end
			lie_pkg::B_JMULW: begin
				if (mrsp.done) begin
					w_q <= mrsp.value;
				end
			end
			lie_pkg::B_TMULW: begin
				if (mrsp.done) begin
					sum_q <= acc.value;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= lie_pkg::B_IDLE;
			held_q <= '0;
			n_q    <= '0;
			i_q    <= '0;
			j_q    <= '0;
			sat_q  <= 1'b0;
			ov_q   <= 1'b0;
			val_q  <= '0;
			stat_q <= lie_pkg::STAT_OK;
			pc_q   <= '0;
		end else begin
			st_q <= st_d;
			if (res_load) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				lie_pkg::B_IDLE: begin
					if (take) begin
						n_q   <= held_q;
						i_q   <= '0;
						j_q   <= CW'(1);
						sat_q <= 1'b0;
						val_q <= '0;
						case (cmd.op)
							lie_pkg::OP_CLEAR: begin
								held_q <= '0;
								pc_q   <= '0;
								stat_q <= lie_pkg::STAT_OK;
							end
							lie_pkg::OP_APPEND: begin
								if (full) begin
									stat_q <= lie_pkg::STAT_FULL;
									pc_q   <= lie_pkg::PCOUNT_W'(held_q);
								end else begin
									stat_q <= lie_pkg::STAT_OK;
									held_q <= held_q + 1'b1;
									pc_q   <= lie_pkg::PCOUNT_W'(held_q + 1'b1);
								end
							end
							lie_pkg::OP_NOP: begin
								stat_q <= lie_pkg::STAT_OK;
								pc_q   <= lie_pkg::PCOUNT_W'(held_q);
							end
							default: begin
								stat_q <= lie_pkg::STAT_OK;
							end
						endcase
					end
				end
				lie_pkg::B_DCHK: begin
					if ((j_q >= n_q) && ((i_q + CW'(2)) < n_q)) begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + CW'(2);
					end else if (j_q >= n_q) begin
						i_q <= '0;
					end
				end
				lie_pkg::B_DCMP: begin
					if (rda_q == rdb_q) begin
						stat_q <= lie_pkg::STAT_DUP;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				lie_pkg::B_ILAT: begin
					j_q <= '0;
				end
				lie_pkg::B_JCHK: begin
					if ((j_q < n_q) && (j_q == i_q)) begin
						j_q <= j_q + 1'b1;
					end
				end
				lie_pkg::B_JDIVW: begin
					if (drsp.done && drsp.sat) begin
						sat_q <= 1'b1;
					end
				end
				lie_pkg::B_JMULW: begin
					if (mrsp.done) begin
						j_q <= j_q + 1'b1;
						if (mrsp.sat) begin
							sat_q <= 1'b1;
						end
					end
				end
				lie_pkg::B_TMULW: begin
					if (mrsp.done) begin
						i_q <= i_q + 1'b1;
						if (mrsp.sat || acc.sat) begin
							sat_q <= 1'b1;
						end
					end
				end
				lie_pkg::B_DONE: begin
					if (out_free) begin
						pc_q <= lie_pkg::PCOUNT_W'(n_q);
						if (stat_q == lie_pkg::STAT_DUP) begin
							val_q <= '0;
						end else begin
							val_q  <= sum_q;
							stat_q <= sat_q ? lie_pkg::STAT_SAT : lie_pkg::STAT_OK;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_ch.valid        = ov_q;
	assign out_ch.interp_value = val_q;
	assign out_ch.status       = stat_q;
	assign out_ch.point_count  = pc_q;

endmodule

// ----- src/lagrange_interpolation_eval.sv -----
// ----------------------------------------------------------------------------
// lagrange_interpolation_eval
// lagrange interpolation over a table of up to 16 points, q16.16 in, q32.32 out
// ----------------------------------------------------------------------------
// channel   dir   payload                               handshake
// in_ch     in    opcode, coord_x, coord_y              valid / ready
// out_ch    out   interp_value, status, point_count     valid / ready
//
// clear, append, unused opcodes: one item a cycle unless evaluating or stalled
// evaluate over n points: a divider pass and a multiply per quotient
// reset clears the point count; the table itself needs no clearing
// a two-entry queue keeps items coming in while evaluation or output stalls
// ----------------------------------------------------------------------------
module lagrange_interpolation_eval (
	input  logic      clk,
	input  logic      arst_n,
	lie_in_if.sink    in_ch,
	lie_out_if.source out_ch
);

	logic          cmd_valid;
	logic          cmd_ready;
	lie_pkg::cmd_t cmd;

	lie_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	lie_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.out_ch    (out_ch)
	);

endmodule

// ----- src/lie_checker.sv -----
// ----------------------------------------------------------------------------
// lie_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
`include "lagrange_interpolation_eval_defines.svh"

module lie_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [63:0]                   interp_value,
	input logic [1:0]                    status,
	input logic [lie_pkg::PCOUNT_W-1:0]  point_count
);

	`LIE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`LIE_ASSERT_NOW(a_full, out_valid && (status == lie_pkg::STAT_FULL), point_count == lie_pkg::PCOUNT_W'(lie_pkg::MAX_POINTS), "full status with table not full")
	`LIE_ASSERT_NOW(a_dup, out_valid && (status == lie_pkg::STAT_DUP), (interp_value == 64'd0) && (point_count >= lie_pkg::PCOUNT_W'(2)), "duplicate result malformed")
	`LIE_ASSERT_NOW(a_cnt, out_valid, point_count <= lie_pkg::PCOUNT_W'(lie_pkg::MAX_POINTS), "point count beyond table")

endmodule

bind lagrange_interpolation_eval lie_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.interp_value (out_ch.interp_value),
	.status       (out_ch.status),
	.point_count  (out_ch.point_count)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lagrange interpolator: a directed table, then
// random clear / append / evaluate sequences, each result checked against a
// fixed-point model of the table, under random idling on both channels
// ----------------------------------------------------------------------------
module tb_top;

	localparam int  RAND_ITEMS  = 1170;
	localparam int  CALM_ITEMS  = 150;
	localparam longint LIMIT    = 8000000;

	typedef struct {
		lie_pkg::op_e op;
		logic [31:0]  x;
		logic [31:0]  y;
		bit           typed;
		logic [63:0]  val;
		logic [1:0]   st;
		logic [4:0]   cnt;
	} row_t;

	typedef struct {
		logic [63:0] val;
		logic [1:0]  st;
		logic [4:0]  cnt;
	} res_t;

	logic clk;
	logic arst_n;

	lie_in_if  in_ch ();
	lie_out_if out_ch ();

	lagrange_interpolation_eval u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	logic [31:0] tbl_x [lie_pkg::MAX_POINTS];
	logic [31:0] tbl_y [lie_pkg::MAX_POINTS];
	int          held;
	res_t        pending_res [$];
	row_t        dir_tab [$];
	int          mismatches;
	longint      cycles = 0;
	bit          calm;
	int          items_sent;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [63:0] mag_of(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [63:0] clamp64(input logic neg, input logic [63:0] mag,
			input logic over, inout logic sat);
		if (neg) begin
			if (over || mag > lie_pkg::SIGN64) begin
				sat = 1'b1;
				return lie_pkg::SIGN64;
			end
			return 64'd0 - mag;
		end
		if (over || mag > lie_pkg::MAXPOS64) begin
			sat = 1'b1;
			return lie_pkg::MAXPOS64;
		end
		return mag;
	endfunction

	function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b,
			input int sh, inout logic sat);
		logic [127:0] p;
		p = {64'd0, mag_of(a)} * {64'd0, mag_of(b)};
		p = p >> sh;
		return clamp64(a[63] ^ b[63], p[63:0], p[127:64] != 0, sat);
	endfunction

	function automatic logic [63:0] fx_div(input logic [63:0] num, input logic [63:0] den,
			inout logic sat);
		logic [127:0] q;
		q = {32'd0, mag_of(num), 32'd0} / {64'd0, mag_of(den)};
		return clamp64(num[63] ^ den[63], q[63:0], q[127:64] != 0, sat);
	endfunction

	function automatic logic [63:0] sx(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic res_t interp_at(input logic [31:0] xq);
		res_t        r;
		logic        sat;
		logic [63:0] sum, w, s, q;
		sat = 1'b0;
		sum = 64'd0;
		r.cnt = held[4:0];
		for (int i = 0; i < held; i++)
			for (int j = i + 1; j < held; j++)
				if (tbl_x[i] == tbl_x[j]) begin
					r.val = 64'd0;
					r.st  = lie_pkg::STAT_DUP;
					return r;
				end
		for (int i = 0; i < held; i++) begin
			w = lie_pkg::ONE_Q32;
			for (int j = 0; j < held; j++)
				if (j != i) begin
					q = fx_div(sx(xq) - sx(tbl_x[j]), sx(tbl_x[i]) - sx(tbl_x[j]), sat);
					w = fx_mul(w, q, 32, sat);
				end
			w = fx_mul(sx(tbl_y[i]), w, 16, sat);
			s = sum + w;
			if (sum[63] == w[63] && s[63] != sum[63]) begin
				sat = 1'b1;
				s   = sum[63] ? lie_pkg::SIGN64 : lie_pkg::MAXPOS64;
			end
			sum = s;
		end
		r.val = sum;
		r.st  = sat ? lie_pkg::STAT_SAT : lie_pkg::STAT_OK;
		return r;
	endfunction

	function automatic res_t table_step(input lie_pkg::op_e op, input logic [31:0] x,
			input logic [31:0] y);
		res_t r;
		r.val = 64'd0;
		r.st  = lie_pkg::STAT_OK;
		case (op)
			lie_pkg::OP_CLEAR: held = 0;
			lie_pkg::OP_APPEND: begin
				if (held >= lie_pkg::MAX_POINTS) begin
					r.st = lie_pkg::STAT_FULL;
				end else begin
					tbl_x[held] = x;
					tbl_y[held] = y;
					held++;
				end
			end
			lie_pkg::OP_EVAL: r = interp_at(x);
			default: ;
		endcase
		if (op != lie_pkg::OP_EVAL)
			r.cnt = held[4:0];
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (mismatches < 10)
			$display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
		mismatches++;
	endtask

	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_res.size() == 0) begin
				flag_mismatch("unexpected item", 64'd0, out_ch.interp_value);
			end else begin
				e = pending_res.pop_front();
				if (out_ch.interp_value !== e.val)
					flag_mismatch("interp_value", e.val, out_ch.interp_value);
				if (out_ch.status !== e.st)
					flag_mismatch("status", e.st, out_ch.status);
				if (out_ch.point_count !== e.cnt)
					flag_mismatch("point_count", e.cnt, out_ch.point_count);
			end
		end
	end

	initial begin
		int stall;
		stall = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				out_ch.ready = 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				stall = $urandom_range(1, 18) - 1;
				out_ch.ready = 1'b0;
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	// entered at a falling edge, returns at the falling edge after acceptance
	task automatic send_cmd(input lie_pkg::op_e op, input logic [31:0] x,
			input logic [31:0] y, input bit typed, input res_t typed_res);
		res_t r;
		if (!calm && $urandom_range(0, 9) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_ch.valid   = 1'b1;
		in_ch.opcode  = op;
		in_ch.coord_x = x;
		in_ch.coord_y = y;
		do @(posedge clk); while (!in_ch.ready);
		r = table_step(op, x, y);
		if (typed)
			r = typed_res;
		pending_res = {pending_res, r};
		items_sent++;
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic send_op(input lie_pkg::op_e op, input logic [31:0] x,
			input logic [31:0] y);
		res_t dummy;
		dummy = '{64'd0, lie_pkg::STAT_OK, 5'd0};
		send_cmd(op, x, y, 1'b0, dummy);
	endtask

	task automatic add_row(input lie_pkg::op_e op, input logic [31:0] x,
			input logic [31:0] y, input bit typed, input logic [63:0] v,
			input logic [1:0] st, input logic [4:0] cnt);
		row_t r;
		r = '{op, x, y, typed, v, st, cnt};
		dir_tab = {dir_tab, r};
	endtask

	function automatic logic [31:0] pick_coord(input int style);
		case (style)
			0: return $urandom;
			1: return $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
			default: return {16'($urandom_range(0, 15) - 8), 16'h0000};
		endcase
	endfunction

	initial begin
		res_t tr;
		int   n, style;
		logic [31:0] px;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.opcode  = lie_pkg::OP_NOP;
		in_ch.coord_x = '0;
		in_ch.coord_y = '0;
		mismatches    = 0;
		calm          = 1'b0;
		items_sent    = 0;
		held          = 0;
		for (int i = 0; i < lie_pkg::MAX_POINTS; i++) begin
			tbl_x[i] = '0;
			tbl_y[i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_row(lie_pkg::OP_EVAL, 32'h0, 32'h0, 1, 64'd0, lie_pkg::STAT_OK, 5'd0);
		add_row(lie_pkg::OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 64'd0,
			lie_pkg::STAT_OK, 5'd0);
		add_row(lie_pkg::OP_CLEAR, 32'h0, 32'h0, 1, 64'd0, lie_pkg::STAT_OK, 5'd0);
		add_row(lie_pkg::OP_APPEND, 32'h0001_0000, 32'h0002_0000, 1, 64'd0,
			lie_pkg::STAT_OK, 5'd1);
		add_row(lie_pkg::OP_EVAL, 32'h0005_0000, 32'h0, 1, 64'h2_0000_0000,
			lie_pkg::STAT_OK, 5'd1);
		add_row(lie_pkg::OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 1, 64'd0,
			lie_pkg::STAT_OK, 5'd2);
		add_row(lie_pkg::OP_EVAL, 32'h7FFF_FFFF, 32'h0, 0, 64'd0, lie_pkg::STAT_OK, 5'd0);
		add_row(lie_pkg::OP_EVAL, 32'h0, 32'h0, 0, 64'd0, lie_pkg::STAT_OK, 5'd0);
		add_row(lie_pkg::OP_APPEND, 32'h0001_0000, 32'h0, 1, 64'd0,
			lie_pkg::STAT_OK, 5'd3);
		add_row(lie_pkg::OP_EVAL, 32'h0, 32'h0, 1, 64'd0, lie_pkg::STAT_DUP, 5'd3);
		add_row(lie_pkg::OP_CLEAR, 32'h0, 32'h0, 1, 64'd0, lie_pkg::STAT_OK, 5'd0);
		add_row(lie_pkg::OP_APPEND, 32'h0, 32'h8000_0000, 1, 64'd0,
			lie_pkg::STAT_OK, 5'd1);
		add_row(lie_pkg::OP_EVAL, 32'h8000_0000, 32'h0, 1, 64'hFFFF_8000_0000_0000,
			lie_pkg::STAT_OK, 5'd1);
		add_row(lie_pkg::OP_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 64'd0,
			lie_pkg::STAT_OK, 5'd0);
		add_row(lie_pkg::OP_APPEND, 32'h8000_0000, 32'h8000_0000, 0, 64'd0,
			lie_pkg::STAT_OK, 5'd0);
		add_row(lie_pkg::OP_EVAL, 32'h4000_0000, 32'h0, 0, 64'd0, lie_pkg::STAT_OK, 5'd0);
		add_row(lie_pkg::OP_EVAL, 32'hC000_0000, 32'h0, 0, 64'd0, lie_pkg::STAT_OK, 5'd0);
		add_row(lie_pkg::OP_NOP, 32'h1234_5678, 32'h8765_4321, 1, 64'd0,
			lie_pkg::STAT_OK, 5'd3);
		add_row(lie_pkg::OP_CLEAR, 32'h0, 32'h0, 1, 64'd0, lie_pkg::STAT_OK, 5'd0);

		foreach (dir_tab[k]) begin
			tr = '{dir_tab[k].val, dir_tab[k].st, dir_tab[k].cnt};
			send_cmd(dir_tab[k].op, dir_tab[k].x, dir_tab[k].y, dir_tab[k].typed, tr);
		end

		items_sent = 0;
		while (items_sent < RAND_ITEMS) begin
			if (items_sent > RAND_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if ($urandom_range(0, 7) == 0) begin
				send_op(lie_pkg::op_e'($urandom_range(0, 3)), $urandom, $urandom);
				continue;
			end
			send_op(lie_pkg::OP_CLEAR, $urandom, $urandom);
			if (items_sent < 3 || $urandom_range(0, 24) == 0)
				n = $urandom_range(15, 18);
			else
				n = $urandom_range(0, 6);
			style = $urandom_range(0, 2);
			for (int i = 0; i < n; i++) begin
				if (held > 0 && $urandom_range(0, 19) == 0)
					px = tbl_x[$urandom_range(0, held - 1)];
				else
					px = pick_coord(style);
				send_op(lie_pkg::OP_APPEND, px, pick_coord($urandom_range(0, 2)));
			end
			repeat ($urandom_range(1, 3)) begin
				if (held > 0 && $urandom_range(0, 4) == 0)
					px = tbl_x[$urandom_range(0, held - 1)];
				else
					px = pick_coord($urandom_range(0, 2));
				send_op(lie_pkg::OP_EVAL, px, $urandom);
			end
		end

		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
